FILE: sv/decimal_digit_add_multiply_core_assert.svh
// Assertion macros shared by the decimal add/multiply core.
`ifndef DECIMAL_DIGIT_ADD_MULTIPLY_CORE_ASSERT_SVH
`define DECIMAL_DIGIT_ADD_MULTIPLY_CORE_ASSERT_SVH

// Same-cycle implication.
`define DDAM_ASSERT_NOW(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DDAM_ASSERT_NEXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ddam_pkg.sv
package ddam_pkg;

  localparam int DIGITS = 32;
  localparam int POS_W  = $clog2(DIGITS);
  localparam int CNT_W  = $clog2(DIGITS + 1);
  // column sum: acc digit + 15*15 + carry <= 260
  localparam int SUM_W   = 9;
  localparam int CARRY_W = 5;

  typedef logic [3:0] digit_t;
  typedef logic [DIGITS-1:0][3:0] digit_vec_t;

  // operand store controls from the sequencer
  typedef struct packed {
    logic load;
    logic clear;
    logic rot_a;
    logic rot_b;
    logic next_row;
  } op_ctl_t;

endpackage

FILE: sv/ddam_digit_unit.sv
module ddam_digit_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic            clear,
  input  logic            mul,
  input  ddam_pkg::digit_t acc_in,
  input  ddam_pkg::digit_t a,
  input  ddam_pkg::digit_t b,
  output ddam_pkg::digit_t digit,
  output logic            carry_nz
);
  import ddam_pkg::*;

  logic [7:0]         prod;
  logic [4:0]         sum_ab;
  logic [SUM_W-1:0]   term;
  logic [SUM_W-1:0]   t;
  logic [16:0]        recip;
  logic [CARRY_W-1:0] quot;
  logic [SUM_W-1:0]   rem;
  logic [CARRY_W-1:0] carry;

  assign prod   = {4'd0, a} * {4'd0, b};
  assign sum_ab = {1'b0, a} + {1'b0, b};
  assign term   = mul ? {1'b0, prod} : {4'd0, sum_ab};
  assign t      = {5'd0, acc_in} + term + {4'd0, carry};

  // t / 10 as (t * 205) >> 11, exact for t up to well past 260
  assign recip  = {8'd0, t} * 17'd205;
  assign quot   = recip[15:11];
  assign rem    = t - ({4'd0, quot} * 9'd10);
  assign digit  = rem[3:0];
  assign carry_nz = (quot != '0);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      carry <= '0;
    end else if (step) begin
      carry <= quot;
    end
  end

endmodule

FILE: sv/ddam_operand_store.sv
module ddam_operand_store (
  input  logic             clk,
  input  logic             rst,
  input  ddam_pkg::op_ctl_t ctl,
  input  ddam_pkg::digit_t  a_in,
  input  ddam_pkg::digit_t  b_in,
  output ddam_pkg::digit_t  a0,
  output ddam_pkg::digit_t  b0,
  output logic             row_ovf,
  output logic             ovf_seen
);
  import ddam_pkg::*;

  digit_vec_t       opa;
  digit_vec_t       opb;
  logic [CNT_W-1:0] count;
  logic             bhigh;

  assign a0 = opa[0];
  assign b0 = opb[0];
  // next row's multiplier digit meets a dropped high digit of b
  assign row_ovf = (opa[1] != '0) && (bhigh || (opb[DIGITS-1] != '0));

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      opa      <= '0;
      opb      <= '0;
      count    <= '0;
      ovf_seen <= 1'b0;
      bhigh    <= 1'b0;
    end else if (ctl.load) begin
      if (count < CNT_W'(DIGITS)) begin
        opa[count[POS_W-1:0]] <= a_in;
        opb[count[POS_W-1:0]] <= b_in;
        count <= count + 1'b1;
      end else if ((a_in != '0) || (b_in != '0)) begin
        ovf_seen <= 1'b1;
      end
    end else if (ctl.next_row) begin
      opa   <= {4'd0, opa[DIGITS-1:1]};
      opb   <= {opb[DIGITS-2:0], 4'd0};
      bhigh <= bhigh || (opb[DIGITS-1] != '0);
    end else begin
      if (ctl.rot_a) begin
        opa <= {opa[0], opa[DIGITS-1:1]};
      end
      if (ctl.rot_b) begin
        opb <= {opb[0], opb[DIGITS-1:1]};
      end
    end
  end

endmodule

FILE: sv/decimal_digit_add_multiply_core.sv
// Decimal add/multiply core, DIGITS (32) decimal digits per operand. Each
// request on the input channel carries one digit of each operand, least
// significant first; the request with last_digit set also picks the
// operation through kind (0 add, 1 multiply) and starts it. Digit pairs past
// DIGITS are dropped and flag overflow if nonzero; digits not loaded are
// zero. The result goes out as DIGITS requests, least significant digit
// first, last_result on the top digit, overflow the same on all of them.
// Everything runs through one digit multiply-add unit, one column per
// cycle. Add makes one pass over the columns, multiply one pass over the
// accumulator per multiplier digit with a shift state between rows, and
// then the result digits are sent. Non-final digit requests for the next
// operation are taken while the result is still being sent; the final one
// waits until the last result digit has gone.
module decimal_digit_add_multiply_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  ddam_pkg::digit_t a_digit,
  input  ddam_pkg::digit_t b_digit,
  input  logic            kind,
  input  logic            last_digit,
  output logic            out_valid,
  input  logic            out_stall,
  output ddam_pkg::digit_t result_digit,
  output logic            overflow,
  output logic            last_result
);
  import ddam_pkg::*;
  `include "decimal_digit_add_multiply_core_assert.svh"

  localparam logic [1:0] S_LOAD = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_NEXT = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(DIGITS - 1);

  logic [1:0]       state;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] row;
  logic             mul_op;
  logic             ovf;
  digit_vec_t       acc;

  op_ctl_t ctl;
  digit_t  a0;
  digit_t  b0;
  digit_t  sum_digit;
  logic    carry_nz;
  logic    row_ovf;
  logic    ovf_seen;
  logic    in_acc;
  logic    out_acc;
  logic    start;
  logic    unit_clear;
  logic    col_last;
  logic    calc_done;

  // a final request must wait while the previous result is still going out
  assign in_stall = (state == S_CALC) || (state == S_NEXT) ||
                    ((state == S_EMIT) && last_digit);
  assign in_acc   = in_valid && !in_stall;
  assign start    = in_acc && last_digit;

  assign out_valid    = (state == S_EMIT);
  assign result_digit = acc[0];
  assign overflow     = ovf;
  assign last_result  = (pos == POS_LAST);
  assign out_acc      = out_valid && !out_stall;

  assign col_last   = (state == S_CALC) && (pos == POS_LAST);
  assign calc_done  = col_last && (!mul_op || (row == POS_LAST));
  assign unit_clear = start || (state == S_NEXT);

  always_comb begin
    ctl          = '0;
    ctl.load     = in_acc;
    ctl.rot_b    = (state == S_CALC);
    ctl.rot_a    = (state == S_CALC) && !mul_op;
    ctl.next_row = (state == S_NEXT);
    ctl.clear    = calc_done;
  end

  ddam_operand_store u_store (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .a_in     (a_digit),
    .b_in     (b_digit),
    .a0       (a0),
    .b0       (b0),
    .row_ovf  (row_ovf),
    .ovf_seen (ovf_seen)
  );

  // accumulator digit enters only when multiplying
  ddam_digit_unit u_unit (
    .clk      (clk),
    .rst      (rst),
    .step     (state == S_CALC),
    .clear    (unit_clear),
    .mul      (mul_op),
    .acc_in   (mul_op ? acc[0] : 4'd0),
    .a        (a0),
    .b        (b0),
    .digit    (sum_digit),
    .carry_nz (carry_nz)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_LOAD;
      pos    <= '0;
      row    <= '0;
      mul_op <= 1'b0;
      ovf    <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (start) begin
            state  <= S_CALC;
            mul_op <= kind;
            pos    <= '0;
            row    <= '0;
            ovf    <= 1'b0;
          end
        end
        S_CALC: begin
          pos <= col_last ? '0 : pos + 1'b1;
          if (col_last) begin
            // carry out of the top column means the true result is wider
            ovf <= ovf || carry_nz || (calc_done && ovf_seen);
            state <= calc_done ? S_EMIT : S_NEXT;
          end
        end
        S_NEXT: begin
          ovf   <= ovf || row_ovf;
          row   <= row + 1'b1;
          state <= S_CALC;
        end
        S_EMIT: begin
          if (out_acc) begin
            pos <= (pos == POS_LAST) ? '0 : pos + 1'b1;
            if (pos == POS_LAST) begin
              state <= S_LOAD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // accumulator: cleared on start, rotated once per column and per sent digit
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
    end else if (state == S_CALC) begin
      acc <= {sum_digit, acc[DIGITS-1:1]};
    end else if (out_acc) begin
      acc <= {acc[0], acc[DIGITS-1:1]};
    end
  end

  `DDAM_ASSERT_NOW(a_digit_range, clk, rst, out_valid, result_digit <= 4'd9, "result digit above 9")
  `DDAM_ASSERT_NEXT(a_emit_end, clk, rst, out_acc && last_result, !out_valid && !in_stall, "no return to load after top digit")
  `DDAM_ASSERT_NEXT(a_done_emit, clk, rst, calc_done, out_valid && (pos == '0), "result not started at digit zero")
  `DDAM_ASSERT_NOW(a_no_start_busy, clk, rst, state != S_LOAD, !start, "operation started while busy")

endmodule
